// ----- rtl/sce_pkg.sv -----
// Shared types and constants of the serial console line editor.
// Holds character codes, result kinds, escape phases and the microcode word.
// Depends on nothing; imported by sce_useq, serial_console_line_editor and tb.
`timescale 1ns / 1ps

package sce_pkg;

  // Character codes
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_HOST  = 2'd2;

  // Register index on the APB port
  localparam logic REG_HOST_ENABLE = 1'b0;

  // Escape sequence tracker
  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_SEEN = 3'b010,
    ESC_CSI  = 3'b100
  } esc_t;

  // Microcode step addresses
  typedef logic [3:0] upc_t;
  localparam upc_t UPC_IDLE  = 4'd0;
  localparam upc_t UPC_CHAR  = 4'd1;
  localparam upc_t UPC_BKSP  = 4'd2;
  localparam upc_t UPC_CR1   = 4'd3;
  localparam upc_t UPC_CR2   = 4'd4;
  localparam upc_t UPC_LF    = 4'd5;
  localparam upc_t UPC_HOST  = 4'd6;
  localparam upc_t UPC_SAVE  = 4'd7;
  localparam upc_t UPC_PR1   = 4'd8;
  localparam upc_t UPC_PR2   = 4'd9;
  localparam upc_t UPC_PR3   = 4'd10;
  localparam upc_t UPC_RCL   = 4'd11;
  localparam upc_t UPC_ERASE = 4'd12;
  localparam upc_t UPC_LOAD  = 4'd13;
  localparam upc_t UPC_COPY  = 4'd14;

  // Microcode word fields
  typedef enum logic [1:0] {EM_NONE, EM_ALWAYS, EM_IF_HOST} emit_t;
  typedef enum logic [1:0] {SRC_CONST, SRC_RX, SRC_LINE, SRC_HIST} src_t;
  typedef enum logic [2:0] {LST_NO, LST_YES, LST_LF, LST_LOOP, LST_ERASE} last_t;
  typedef enum logic [2:0] {
    JMP_NEXT, JMP_GOTO, JMP_LOOP, JMP_LZERO, JMP_HZERO, JMP_DISPATCH
  } jmp_t;
  typedef enum logic [1:0] {IDX_HOLD, IDX_CLR, IDX_INC} idx_op_t;
  typedef enum logic [2:0] {LC_HOLD, LC_INC, LC_DEC, LC_CLR, LC_HIST} lc_op_t;
  typedef enum logic [1:0] {WR_NONE, WR_LINE_RX, WR_LINE_HIST, WR_HIST_LINE} wr_t;

  typedef struct packed {
    emit_t      emit;
    src_t       src;
    logic [7:0] chr;
    logic [1:0] kind;
    last_t      last;
    logic       line_end;
    jmp_t       jmp;
    upc_t       target;
    idx_op_t    idx_op;
    lc_op_t     lc_op;
    logic       hc_load;
    wr_t        wr;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic line_zero;
    logic line_full;
    logic hist_zero;
    logic loop_end;
    logic slot_free;
    logic host_en;
  } cond_t;

endpackage

// ----- rtl/serial_console_line_editor.sv -----
// Serial console line editor: takes received bytes and returns echo, erase
// and host-line beats. Top level with datapath, output register and APB port.
// Depends on sce_pkg, sce_useq and sce_bufs.
//
// Usage:
//   in_*  : one received byte per beat (valid/ready).
//   out_* : result beats (valid/ready); out_last marks the final beat of
//           the results caused by one input byte. Bytes with no result
//           produce no beat.
//   APB   : register 0 (address 0) is host_enable, bit 0. Write it only
//           while the block is idle. pready is tied high.
// Sequence: a byte is accepted and dispatched, then microcode steps run:
//   an ordinary byte runs the CHAR step, a backspace the BKSP step; CR/LF
//   runs CR1, CR2, LF, then the host copy loop and SAVE (empty line: PR1-PR3),
//   and history recall runs RCL, the erase loop, LOAD and the copy loop.
//   The copy and erase loops move one character per cycle unless stalled.
// Results pass through a single output register; a stalled receiver holds
//   the sequencer at its next emitting step, and a new byte is accepted
//   while the last result still waits. The first result beat of a byte is
//   loaded by the first emitting step after its dispatch step.
// Reset (rst_n, synchronous): line and history empty, no escape pending,
//   host_enable cleared, output empty. No clearing pass is needed.
`timescale 1ns / 1ps

module serial_console_line_editor
  import sce_pkg::*;
#(
  parameter int LINE_MAX = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_line_end,
  output logic        out_last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int   CNT_W           = $clog2(LINE_MAX + 1);

  logic             host_en_r;
  logic [CNT_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [CNT_W-1:0] hist_cnt_r, hist_cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       rx_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic [1:0]       out_kind_r;
  logic             out_line_end_r;
  logic             out_last_r;

  cond_t            cond;
  uword_t           uw;
  logic             fire;
  logic             emit_go;
  logic             loop_end;
  logic             line_we, hist_we;
  logic [CNT_W-1:0] waddr;
  logic [7:0]       wdata;
  logic [7:0]       line_rd, hist_rd;
  logic [7:0]       res_byte;
  logic             res_last;

  // status for the sequencer
  assign loop_end = ((idx_r + CNT_W'(1)) == line_cnt_r);
  assign cond = '{line_zero: (line_cnt_r == '0),
                  line_full: (line_cnt_r == CNT_W'(LINE_MAX)),
                  hist_zero: (hist_cnt_r == '0),
                  loop_end:  loop_end,
                  slot_free: (!out_valid_r || out_ready),
                  host_en:   host_en_r};

  sce_useq u_useq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .cond       (cond),
    .in_ready   (in_ready),
    .uw         (uw),
    .fire       (fire),
    .emit_go    (emit_go)
  );

  // buffer writes
  always_comb begin
    line_we = 1'b0;
    hist_we = 1'b0;
    waddr   = idx_r;
    wdata   = rx_r;
    case (uw.wr)
      WR_LINE_RX: begin
        line_we = fire;
        waddr   = line_cnt_r;
      end
      WR_LINE_HIST: begin
        line_we = fire;
        wdata   = hist_rd;
      end
      WR_HIST_LINE: begin
        hist_we = fire;
        wdata   = line_rd;
      end
      default: ;
    endcase
  end

  sce_bufs #(
    .LINE_MAX (LINE_MAX)
  ) u_bufs (
    .clk     (clk),
    .line_we (line_we),
    .hist_we (hist_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (idx_nxt),
    .line_rd (line_rd),
    .hist_rd (hist_rd)
  );

  // index and counts; the read address follows the next index
  always_comb begin
    idx_nxt      = idx_r;
    line_cnt_nxt = line_cnt_r;
    hist_cnt_nxt = hist_cnt_r;
    if (fire) begin
      case (uw.idx_op)
        IDX_CLR: idx_nxt = '0;
        IDX_INC: idx_nxt = idx_r + CNT_W'(1);
        default: ;
      endcase
      case (uw.lc_op)
        LC_INC:  line_cnt_nxt = line_cnt_r + CNT_W'(1);
        LC_DEC:  line_cnt_nxt = line_cnt_r - CNT_W'(1);
        LC_CLR:  line_cnt_nxt = '0;
        LC_HIST: line_cnt_nxt = hist_cnt_r;
        default: ;
      endcase
      if (uw.hc_load) hist_cnt_nxt = line_cnt_r;
    end
  end

  // result beat contents
  always_comb begin
    case (uw.src)
      SRC_RX:   res_byte = rx_r;
      SRC_LINE: res_byte = line_rd;
      SRC_HIST: res_byte = hist_rd;
      default:  res_byte = uw.chr;
    endcase
    case (uw.last)
      LST_YES:   res_last = 1'b1;
      LST_LF:    res_last = !cond.line_zero && !host_en_r;
      LST_LOOP:  res_last = loop_end;
      LST_ERASE: res_last = loop_end && cond.hist_zero;
      default:   res_last = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_en_r   <= 1'b0;
      line_cnt_r  <= '0;
      hist_cnt_r  <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_HOST_ENABLE)) begin
        host_en_r <= pwdata[0];
      end
      line_cnt_r <= line_cnt_nxt;
      hist_cnt_r <= hist_cnt_nxt;
      idx_r      <= idx_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rx_r <= in_rx_byte;
    end
    if (emit_go) begin
      out_byte_r     <= res_byte;
      out_kind_r     <= uw.kind;
      out_line_end_r <= uw.line_end && loop_end;
      out_last_r     <= res_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_kind     = out_kind_r;
  assign out_line_end = out_line_end_r;
  assign out_last     = out_last_r;

  // register read
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HOST_ENABLE) ? {31'd0, host_en_r} : 32'd0;

  // checks
  a_line_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_cnt_r <= CNT_W'(LINE_MAX))
    else $error("line count above limit");

  a_hist_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hist_cnt_r <= CNT_W'(LINE_MAX))
    else $error("history count above limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && out_valid_r) |-> out_ready)
    else $error("result loaded over a beat not yet taken");

  a_line_end_host: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_end) |-> (out_kind == KIND_HOST && out_last))
    else $error("line end on a beat that does not close a host line");

  a_erase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_ERASE) |-> (out_byte == CH_NUL))
    else $error("erase beat carries a nonzero byte");

endmodule

// ----- rtl/sce_bufs.sv -----
// Line and history buffers of the serial console line editor.
// Two single-write memories with registered reads at a shared address.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module sce_bufs #(
  parameter int LINE_MAX = 31
) (
  input  logic                                clk,
  input  logic                                line_we,
  input  logic                                hist_we,
  input  logic [$clog2(LINE_MAX + 1) - 1:0]   waddr,
  input  logic [7:0]                          wdata,
  input  logic [$clog2(LINE_MAX + 1) - 1:0]   raddr,
  output logic [7:0]                          line_rd,
  output logic [7:0]                          hist_rd
);

  localparam int CNT_W = $clog2(LINE_MAX + 1);
  localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  logic [7:0] line_mem [LINE_MAX];
  logic [7:0] hist_mem [LINE_MAX];
  logic [7:0] line_rd_r;
  logic [7:0] hist_rd_r;

  // writes, and reads registered; the read address can run one past the end
  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[waddr[IDX_W-1:0]] <= wdata;
    end
    if (hist_we) begin
      hist_mem[waddr[IDX_W-1:0]] <= wdata;
    end
    if (raddr < CNT_W'(LINE_MAX)) begin
      line_rd_r <= line_mem[raddr[IDX_W-1:0]];
      hist_rd_r <= hist_mem[raddr[IDX_W-1:0]];
    end
  end

  assign line_rd = line_rd_r;
  assign hist_rd = hist_rd_r;

endmodule

// ----- rtl/sce_useq.sv -----
// Microcode sequencer of the serial console line editor.
// Step counter, control store, byte dispatch and escape tracking.
// Depends on sce_pkg.
`timescale 1ns / 1ps

module sce_useq
  import sce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  input  cond_t      cond,
  output logic       in_ready,
  output uword_t     uw,
  output logic       fire,
  output logic       emit_go
);

  upc_t pc_r, pc_nxt;
  esc_t esc_r, esc_nxt;
  logic needs_emit;

  // control store: one word per step
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    w = '{emit: EM_NONE, src: SRC_CONST, chr: CH_NUL, kind: KIND_BYTE,
          last: LST_NO, line_end: 1'b0, jmp: JMP_GOTO, target: UPC_IDLE,
          idx_op: IDX_HOLD, lc_op: LC_HOLD, hc_load: 1'b0, wr: WR_NONE};
    case (pc)
      UPC_IDLE: begin
        w.jmp = JMP_DISPATCH;
      end
      UPC_CHAR: begin
        w.emit = EM_ALWAYS; w.src = SRC_RX; w.last = LST_YES;
        w.lc_op = LC_INC; w.wr = WR_LINE_RX;
      end
      UPC_BKSP: begin
        w.emit = EM_ALWAYS; w.kind = KIND_ERASE; w.last = LST_YES;
        w.lc_op = LC_DEC;
      end
      UPC_CR1, UPC_CR2: begin
        w.emit = EM_ALWAYS; w.chr = CH_CR; w.jmp = JMP_NEXT;
      end
      UPC_LF: begin
        w.emit = EM_ALWAYS; w.chr = CH_LF; w.last = LST_LF;
        w.jmp = JMP_LZERO; w.target = UPC_PR1; w.idx_op = IDX_CLR;
      end
      UPC_HOST: begin
        w.emit = EM_IF_HOST; w.src = SRC_LINE; w.kind = KIND_HOST;
        w.last = LST_LOOP; w.line_end = 1'b1; w.jmp = JMP_LOOP;
        w.target = UPC_SAVE; w.idx_op = IDX_INC; w.wr = WR_HIST_LINE;
      end
      UPC_SAVE: begin
        w.hc_load = 1'b1; w.lc_op = LC_CLR;
      end
      UPC_PR1: begin
        w.emit = EM_ALWAYS; w.chr = CH_DOLLAR; w.jmp = JMP_NEXT;
      end
      UPC_PR2: begin
        w.emit = EM_ALWAYS; w.chr = CH_COLON; w.jmp = JMP_NEXT;
      end
      UPC_PR3: begin
        w.emit = EM_ALWAYS; w.chr = CH_SPACE; w.last = LST_YES;
      end
      UPC_RCL: begin
        w.jmp = JMP_LZERO; w.target = UPC_LOAD; w.idx_op = IDX_CLR;
      end
      UPC_ERASE: begin
        w.emit = EM_ALWAYS; w.kind = KIND_ERASE; w.last = LST_ERASE;
        w.jmp = JMP_LOOP; w.target = UPC_LOAD; w.idx_op = IDX_INC;
      end
      UPC_LOAD: begin
        w.jmp = JMP_HZERO; w.target = UPC_IDLE; w.idx_op = IDX_CLR;
        w.lc_op = LC_HIST;
      end
      UPC_COPY: begin
        w.emit = EM_ALWAYS; w.src = SRC_HIST; w.last = LST_LOOP;
        w.jmp = JMP_LOOP; w.target = UPC_IDLE; w.idx_op = IDX_INC;
        w.wr = WR_LINE_HIST;
      end
      default: begin
        w.jmp = JMP_GOTO;
      end
    endcase
    return w;
  endfunction

  assign uw         = ucode_rom(pc_r);
  assign in_ready   = (uw.jmp == JMP_DISPATCH);
  assign needs_emit = (uw.emit == EM_ALWAYS) || ((uw.emit == EM_IF_HOST) && cond.host_en);
  // a step retires when its beat (if any) can be loaded into the output register
  assign fire       = in_ready ? in_valid : (!needs_emit || cond.slot_free);
  assign emit_go    = fire && needs_emit;

  // next step and escape phase
  always_comb begin
    pc_nxt  = pc_r;
    esc_nxt = esc_r;
    if (fire) begin
      case (uw.jmp)
        JMP_NEXT:  pc_nxt = pc_r + 1'b1;
        JMP_GOTO:  pc_nxt = uw.target;
        JMP_LOOP:  pc_nxt = cond.loop_end ? uw.target : pc_r;
        JMP_LZERO: pc_nxt = cond.line_zero ? uw.target : pc_r + 1'b1;
        JMP_HZERO: pc_nxt = cond.hist_zero ? uw.target : pc_r + 1'b1;
        JMP_DISPATCH: begin
          pc_nxt  = UPC_IDLE;
          esc_nxt = ESC_IDLE;
          case (esc_r)
            ESC_SEEN: begin
              if (in_rx_byte == CH_LBRK) esc_nxt = ESC_CSI;
            end
            ESC_CSI: begin
              if (in_rx_byte == CH_UP) pc_nxt = UPC_RCL;
            end
            default: begin
              if (in_rx_byte == CH_CR || in_rx_byte == CH_LF) begin
                pc_nxt = UPC_CR1;
              end else if (in_rx_byte == CH_BS || in_rx_byte == CH_DEL) begin
                if (!cond.line_zero) pc_nxt = UPC_BKSP;
              end else if (in_rx_byte == CH_ESC) begin
                esc_nxt = ESC_SEEN;
              end else if (!cond.line_full) begin
                pc_nxt = UPC_CHAR;
              end
            end
          endcase
        end
        default: pc_nxt = UPC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= UPC_IDLE;
      esc_r <= ESC_IDLE;
    end else begin
      pc_r  <= pc_nxt;
      esc_r <= esc_nxt;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for serial_console_line_editor: drives received bytes
// and APB writes, and predicts every echo, erase and host-line beat in a small class.
// Depends on sce_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module tb
  import sce_pkg::*;
();

  localparam int LINE_LIMIT     = 31;
  localparam logic [2:0] HOST_ENABLE_ADDR = {REG_HOST_ENABLE, 2'b00};
  localparam int DRAIN_CYCLES   = 80;     // longest microcode walk plus margin
  localparam int HOLD_CYCLES    = 400;    // long receiver back-pressure stretch
  localparam int CYCLE_LIMIT    = 1000000;

  // Expected result beat
  typedef struct packed {
    logic [7:0] chr;
    logic [1:0] kind;
    logic       line_end;
    logic       last;
  } beat_t;

  // Line editor predictor plus result checker
  class console_scoreboard;
    beat_t      expected_q[$];
    beat_t      staged_q[$];
    logic [7:0] line_buf[LINE_LIMIT];
    logic [7:0] hist_buf[LINE_LIMIT];
    int         line_len;
    int         hist_len;
    esc_t       esc_state;
    logic       host_en;
    int         errors;
    int         beats_checked;
    int         lines_delivered;
    int         recalls;
    int         full_drops;

    function new();
      line_len  = 0;
      hist_len  = 0;
      esc_state = ESC_IDLE;
      host_en   = 1'b0;
      errors    = 0;
      beats_checked   = 0;
      lines_delivered = 0;
      recalls         = 0;
      full_drops      = 0;
      foreach (line_buf[i]) begin
        line_buf[i] = '0;
        hist_buf[i] = '0;
      end
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void stage(logic [7:0] chr, logic [1:0] kind, logic line_end);
      beat_t t;
      t.chr      = chr;
      t.kind     = kind;
      t.line_end = line_end;
      t.last     = 1'b0;
      staged_q.push_back(t);
    endfunction

    // Apply one accepted byte; returns how many beats it should produce
    function int note_input(logic [7:0] b);
      beat_t t;
      int    n;
      staged_q = {};
      case (esc_state)
        ESC_SEEN: esc_state = (b == CH_LBRK) ? ESC_CSI : ESC_IDLE;
        ESC_CSI: begin
          esc_state = ESC_IDLE;
          // up arrow: erase current line, then replay history
          if (b == CH_UP) begin
            recalls++;
            for (int i = 0; i < line_len; i++) stage(CH_NUL, KIND_ERASE, 1'b0);
            line_len = hist_len;
            for (int i = 0; i < line_len; i++) begin
              line_buf[i] = hist_buf[i];
              stage(line_buf[i], KIND_BYTE, 1'b0);
            end
          end
        end
        default: begin
          esc_state = ESC_IDLE;
          if (b == CH_CR || b == CH_LF) begin
            stage(CH_CR, KIND_BYTE, 1'b0);
            stage(CH_CR, KIND_BYTE, 1'b0);
            stage(CH_LF, KIND_BYTE, 1'b0);
            if (line_len > 0) begin
              if (host_en) begin
                lines_delivered++;
                for (int i = 0; i < line_len; i++)
                  stage(line_buf[i], KIND_HOST, i == line_len - 1);
              end
              for (int i = 0; i < line_len; i++) hist_buf[i] = line_buf[i];
              hist_len = line_len;
              line_len = 0;
            end else begin
              stage(CH_DOLLAR, KIND_BYTE, 1'b0);
              stage(CH_COLON, KIND_BYTE, 1'b0);
              stage(CH_SPACE, KIND_BYTE, 1'b0);
            end
          end else if (b == CH_BS || b == CH_DEL) begin
            if (line_len > 0) begin
              line_len--;
              stage(CH_NUL, KIND_ERASE, 1'b0);
            end
          end else if (b == CH_ESC) begin
            esc_state = ESC_SEEN;
          end else if (line_len < LINE_LIMIT) begin
            line_buf[line_len] = b;
            line_len++;
            stage(b, KIND_BYTE, 1'b0);
          end else begin
            full_drops++;
          end
        end
      endcase
      n = staged_q.size();
      for (int i = 0; i < n; i++) begin
        t      = staged_q[i];
        t.last = (i == n - 1);
        expected_q.push_back(t);
      end
      return n;
    endfunction

    function void check_result(logic [7:0] chr, logic [1:0] kind, logic line_end,
                               logic last);
      beat_t e;
      if (expected_q.size() == 0) begin
        fail($sformatf("unexpected beat: byte %02h kind %0d end %0b last %0b",
                       chr, kind, line_end, last));
        return;
      end
      e = expected_q.pop_front();
      beats_checked++;
      if (e.chr !== chr || e.kind !== kind || e.line_end !== line_end || e.last !== last)
        fail($sformatf({"beat %0d: expected byte %02h kind %0d end %0b last %0b, ",
                        "got byte %02h kind %0d end %0b last %0b"},
                       beats_checked, e.chr, e.kind, e.line_end, e.last,
                       chr, kind, line_end, last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_line_end;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  console_scoreboard sb;
  int   cycles;
  int   beats_sent;
  int   answered_items;
  int   burst_left;
  bit   hold_req;
  bit   hold_fired;
  int   hold_left;
  logic [7:0] stall_mask;
  int   stall_slot;
  int   stall_window;

  serial_console_line_editor #(.LINE_MAX(LINE_LIMIT)) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_kind     (out_kind),
    .out_line_end (out_line_end),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_byte, out_kind, out_line_end, out_last);
  end

  // Receiver: rotating stall mask, reshuffled per window, plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_ready  <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      hold_left  <= HOLD_CYCLES - 1;
      out_ready  <= 1'b0;
    end else begin
      if (stall_window == 0) begin
        stall_window = $urandom_range(30, 150);
        stall_mask   = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      end else begin
        stall_window--;
      end
      stall_slot = (stall_slot + 1) % 8;
      out_ready <= stall_mask[stall_slot];
    end
  end

  // Offer one byte, in bursts of random length separated by random gaps
  task offer_byte(input logic [7:0] b);
    int n;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 4) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 10);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    n = sb.note_input(b);
    if (n > 0) answered_items++;
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task stop_input();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
  endtask

  // Wait until every expected beat is back and the sequencer has finished
  task settle();
    stop_input();
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task set_host_enable(input logic en);
    logic [31:0] rd;
    apb_write(HOST_ENABLE_ADDR, {31'b0, en});
    sb.host_en = en;
    @(posedge clk);
    apb_read(HOST_ENABLE_ADDR, rd);
    if (rd[0] !== en)
      sb.fail($sformatf("host_enable readback %0b, wrote %0b", rd[0], en));
  endtask

  // Mostly printable, sometimes any byte other than BS, DEL, ESC, CR and LF
  function logic [7:0] pick_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h20, 8'h7E));
    do c = 8'($urandom_range(0, 255));
    while (c == CH_BS || c == CH_DEL || c == CH_ESC || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  task type_line(input int len, input bit with_edits);
    for (int i = 0; i < len; i++) begin
      if (with_edits && $urandom_range(0, 7) == 0)
        offer_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
      else
        offer_byte(pick_char());
    end
    offer_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task random_sequence(input bit force_long);
    int pick;
    int n;
    pick = force_long ? 45 : $urandom_range(0, 99);
    if (pick < 40) begin
      type_line($urandom_range(1, 12), 1'b1);
    end else if (pick < 52) begin
      // can run past a full line
      type_line($urandom_range(29, 36), 1'b0);
    end else if (pick < 67) begin
      // history recall, optional edit, usually submitted
      offer_byte(CH_ESC);
      offer_byte(CH_LBRK);
      offer_byte(CH_UP);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
        offer_byte($urandom_range(0, 2) == 0 ? CH_DEL : pick_char());
      if ($urandom_range(0, 3) != 0) offer_byte(CH_CR);
    end else if (pick < 75) begin
      offer_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    end else if (pick < 85) begin
      // escape with a random final byte, usually broken
      offer_byte(CH_ESC);
      if ($urandom_range(0, 1)) offer_byte(CH_LBRK);
      offer_byte(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) offer_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task random_phase(input int answered_goal, input bit with_hold);
    int goal;
    goal = answered_items + answered_goal;
    // long hold-off while a long line is typed, so the input backs up
    if (with_hold && !hold_fired) begin
      hold_req   = 1'b1;
      hold_fired = 1'b1;
    end
    random_sequence(1'b1);
    while (answered_items < goal) begin
      random_sequence(1'b0);
    end
  endtask

  // Directed bytes: empty prompt, empty recall, extremes, erase on empty,
  // saved line with host off, broken escapes, recall, resubmit
  logic [7:0] directed_bytes[23] = '{
    CH_CR, CH_ESC, CH_LBRK, CH_UP, 8'h00, 8'hFF, 8'h61, CH_BS, CH_DEL, CH_BS,
    CH_DEL, 8'h68, 8'h69, CH_LF, CH_ESC, 8'h78, CH_ESC, CH_LBRK, 8'h42,
    CH_ESC, CH_LBRK, CH_UP, CH_CR
  };

  // Main sequence
  initial begin
    sb           = new();
    cycles       = 0;
    beats_sent   = 0;
    answered_items = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    hold_fired   = 1'b0;
    hold_left    = 0;
    stall_mask   = 8'hFF;
    stall_slot   = 0;
    stall_window = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    out_ready  <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_host_enable(1'b0);
    foreach (directed_bytes[i]) offer_byte(directed_bytes[i]);
    settle();

    set_host_enable(1'b1);
    random_phase(40, 1'b1);
    settle();

    set_host_enable(1'b0);
    random_phase(40, 1'b0);
    settle();

    set_host_enable(1'b1);
    random_phase(40, 1'b0);
    settle();

    $display("Sent %0d bytes (%0d with output), checked %0d beats: %0d host lines, %0d recalls,",
             beats_sent, answered_items, sb.beats_checked, sb.lines_delivered, sb.recalls);
    $display("%0d bytes dropped on a full line; host_enable toggled, one %0d-cycle output hold-off.",
             sb.full_drops, HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d beats never seen", sb.errors, sb.pending());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sce_pkg.sv
rtl/sce_bufs.sv
rtl/sce_useq.sv
rtl/serial_console_line_editor.sv
tb/tb.sv
